@@ rtl/stbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, mode codes, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int MODE_W        = 2;
    localparam int KEY_W         = 32;
    localparam int ADDR_W        = 10;
    localparam int ENTRY_COUNT_W = 11;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXACT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOWER = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_STEP,
        ST_FINAL,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_MISS,
        RES_MATCH,
        RES_FINAL
    } t_res_sel;

    typedef struct packed {
        logic     in_ready;
        logic     start;
        logic     probe;
        logic     step;
        t_res_sel set_res;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_query;
        logic empty;
        logic is_exact;
        logic cur_more;
        logic match;
        logic step_more;
        logic out_free;
    } t_status;

endpackage

@@ rtl/stbs_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table search channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface stbs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [stbs_pkg::MODE_W-1:0]          mode;
    logic signed [stbs_pkg::KEY_W-1:0]    key_value;
    logic [stbs_pkg::ADDR_W-1:0]          entry_address;

    modport source (output valid, output mode, output key_value, output entry_address,
                    input ready);
    modport sink (input valid, input mode, input key_value, input entry_address,
                  output ready);
endinterface

interface stbs_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic [stbs_pkg::ADDR_W-1:0]          result_index;

    modport source (output valid, output found, output result_index, input ready);
    modport sink (input valid, input found, input result_index, output ready);
endinterface

@@ rtl/stbs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table search datapath
// Table memory, entry count register, search bounds, key compare, pending
// result and output register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stbs_pkg::ENTRY_COUNT_W-1:0]   i_cfg_wdata,
    stbs_in_if.sink                              i_item,
    stbs_out_if.source                           o_result,
    input  stbs_pkg::t_cmd                       i_cmd,
    output stbs_pkg::t_status                    o_status
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = IW + 1;

    logic signed [stbs_pkg::KEY_W-1:0] mem [TABLE_DEPTH];

    logic [stbs_pkg::ENTRY_COUNT_W-1:0] r_entry_count;
    logic signed [stbs_pkg::KEY_W-1:0]  r_key;
    logic                               r_exact;
    logic [LW-1:0]                      r_lo;
    logic [LW-1:0]                      r_hi;
    logic [IW-1:0]                      r_mid;
    logic signed [stbs_pkg::KEY_W-1:0]  r_rd_data;
    logic                               r_res_found;
    logic [stbs_pkg::ADDR_W-1:0]        r_res_idx;
    logic                               r_out_valid;
    logic                               r_out_found;
    logic [stbs_pkg::ADDR_W-1:0]        r_out_idx;

    logic [LW-1:0]  count;
    logic [LW-1:0]  n_lo;
    logic [LW-1:0]  n_hi;
    logic [IW-1:0]  mid_cur;
    logic [IW-1:0]  mid_next;
    logic [IW-1:0]  rd_addr;
    logic           lt;
    logic           accept;
    logic           load_we;

    // Midpoint of the live range; exact mode keeps the upper bound exclusive.
    function automatic logic [IW-1:0] midpoint(input logic [LW-1:0] lo,
                                               input logic [LW-1:0] hi,
                                               input logic exact);
        logic [LW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - {{LW{1'b0}}, exact};
        return IW'(sum >> 1);
    endfunction

    always_comb begin
        if (32'(r_entry_count) > 32'(TABLE_DEPTH)) begin
            count = LW'(TABLE_DEPTH);
        end else begin
            count = LW'(r_entry_count);
        end
    end

    assign accept  = i_item.valid && i_cmd.in_ready;
    assign load_we = accept && (i_item.mode == stbs_pkg::MODE_LOAD)
                     && (32'(i_item.entry_address) < 32'(TABLE_DEPTH));

    assign lt       = r_rd_data < r_key;
    assign n_lo     = lt ? (LW'(r_mid) + LW'(1)) : r_lo;
    assign n_hi     = lt ? r_hi : LW'(r_mid);
    assign mid_cur  = midpoint(r_lo, r_hi, r_exact);
    assign mid_next = midpoint(n_lo, n_hi, r_exact);

    always_comb begin
        if (i_cmd.step) begin
            rd_addr = (n_lo < n_hi) ? mid_next : IW'(n_lo);
        end else if (r_lo < r_hi) begin
            rd_addr = mid_cur;
        end else begin
            rd_addr = IW'(r_lo);
        end
    end

    always_comb begin
        o_status.in_valid  = i_item.valid;
        o_status.in_query  = (i_item.mode == stbs_pkg::MODE_EXACT)
                             || (i_item.mode == stbs_pkg::MODE_LOWER);
        o_status.empty     = (count == '0);
        o_status.is_exact  = r_exact;
        o_status.cur_more  = r_lo < r_hi;
        o_status.match     = r_rd_data == r_key;
        o_status.step_more = n_lo < n_hi;
        o_status.out_free  = !r_out_valid || o_result.ready;
    end

    assign i_item.ready          = i_cmd.in_ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out_found;
    assign o_result.result_index = r_out_idx;

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem[IW'(i_item.entry_address)] <= i_item.key_value;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key   <= i_item.key_value;
            r_exact <= i_item.mode == stbs_pkg::MODE_EXACT;
            r_lo    <= '0;
            r_hi    <= (i_item.mode == stbs_pkg::MODE_EXACT) ? count : count - LW'(1);
        end else if (i_cmd.step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_cmd.probe || i_cmd.step) begin
            r_mid <= rd_addr;
        end
        case (i_cmd.set_res)
            stbs_pkg::RES_MISS: begin
                r_res_found <= 1'b0;
                r_res_idx   <= '0;
            end
            stbs_pkg::RES_MATCH: begin
                r_res_found <= 1'b1;
                r_res_idx   <= stbs_pkg::ADDR_W'(r_mid);
            end
            stbs_pkg::RES_FINAL: begin
                r_res_found <= !lt;
                r_res_idx   <= lt ? '0 : stbs_pkg::ADDR_W'(r_mid);
            end
            default: begin
            end
        endcase
        if (i_cmd.emit) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
        end
    end

endmodule

@@ rtl/stbs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table search controller
// Sequences accept, probe, halving steps, final check and result hand-off.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stbs_pkg::t_status   i_status,
    output stbs_pkg::t_cmd      o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (i_status.in_valid && i_status.in_query) begin
                    n_state = i_status.empty ? stbs_pkg::ST_RESULT : stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE: begin
                n_state = i_status.cur_more ? stbs_pkg::ST_STEP : stbs_pkg::ST_FINAL;
            end
            stbs_pkg::ST_STEP: begin
                if (i_status.is_exact && i_status.match) begin
                    n_state = stbs_pkg::ST_RESULT;
                end else if (i_status.step_more) begin
                    n_state = stbs_pkg::ST_STEP;
                end else if (i_status.is_exact) begin
                    n_state = stbs_pkg::ST_RESULT;
                end else begin
                    n_state = stbs_pkg::ST_FINAL;
                end
            end
            stbs_pkg::ST_FINAL: begin
                n_state = stbs_pkg::ST_RESULT;
            end
            stbs_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    n_state = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '{in_ready: 1'b0, start: 1'b0, probe: 1'b0, step: 1'b0,
                  set_res: stbs_pkg::RES_HOLD, emit: 1'b0};
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.start    = i_status.in_valid && i_status.in_query;
                if (i_status.in_valid && i_status.in_query && i_status.empty) begin
                    o_cmd.set_res = stbs_pkg::RES_MISS;
                end
            end
            stbs_pkg::ST_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            stbs_pkg::ST_STEP: begin
                o_cmd.step = 1'b1;
                if (i_status.is_exact && i_status.match) begin
                    o_cmd.set_res = stbs_pkg::RES_MATCH;
                end else if (i_status.is_exact && !i_status.step_more) begin
                    o_cmd.set_res = stbs_pkg::RES_MISS;
                end
            end
            stbs_pkg::ST_FINAL: begin
                o_cmd.set_res = stbs_pkg::RES_FINAL;
            end
            stbs_pkg::ST_RESULT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/sorted_table_binary_search_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search
// Loadable table of signed values with exact-match and lower-bound search.
// ----------------------------------------------------------------------------
// A load word writes one table entry in the cycle it is accepted. A query word
// runs a binary search over the first entry_count entries (clamped to
// TABLE_DEPTH), one halving step per cycle, each step one read of the table
// memory and one signed compare. After acceptance the controller moves through
// the probe read, the halving steps and, in lower-bound mode, the final check
// of the one entry left before it offers the result; exact mode stops early
// when a probe hits the key, and an empty table goes straight to the result.
// The block takes one word at a time and accepts the next once the result has
// moved to the output register, so a result that is not yet taken holds the
// next query back. Entries must be loaded before a query can reach them; the
// table has no reset value.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stbs_pkg::ENTRY_COUNT_W-1:0]   i_cfg_wdata,
    stbs_in_if.sink                              i_item,
    stbs_out_if.source                           o_result
);

    stbs_pkg::t_cmd    cmd;
    stbs_pkg::t_status status;

    stbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .o_result    (o_result),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table binary search testbench
// Loads ascending and scrambled tables, runs exact-match and lower-bound
// queries over many entry counts, and compares every result word with an
// independent search over a private copy of the table.
// ----------------------------------------------------------------------------
localparam int TABLE_ENTRIES = 1024;

typedef struct packed {
    logic                        found;
    logic [stbs_pkg::ADDR_W-1:0] index;
} t_answer;

class table_search_tracker;
    int          entry_vals[TABLE_ENTRIES];
    int unsigned entry_count;
    t_answer     pending_answers[$];
    int          fail_count;

    function new();
        foreach (entry_vals[i]) entry_vals[i] = 0;
        entry_count = 0;
        fail_count  = 0;
    endfunction

    function void set_entry_count(logic [stbs_pkg::ENTRY_COUNT_W-1:0] value);
        entry_count = 32'(value);
    endfunction

    // Counts beyond the table depth search the whole table.
    function int live_entries();
        return (entry_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(entry_count);
    endfunction

    function int find_exact(int key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = live_entries() - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (entry_vals[mid] == key) return mid;
            if (entry_vals[mid] < key) lo = mid + 1;
            else hi = mid - 1;
        end
        return -1;
    endfunction

    function int find_lower_bound(int key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = live_entries() - 1;
        if (hi < 0) return -1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (entry_vals[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        return (entry_vals[lo] >= key) ? lo : -1;
    endfunction

    function void note_word(logic [stbs_pkg::MODE_W-1:0] mode, int key,
                            logic [stbs_pkg::ADDR_W-1:0] addr);
        int      hit;
        t_answer ans;
        if (mode == stbs_pkg::MODE_LOAD) begin
            entry_vals[addr] = key;
            return;
        end
        if (mode != stbs_pkg::MODE_EXACT && mode != stbs_pkg::MODE_LOWER) return;
        hit = (mode == stbs_pkg::MODE_EXACT) ? find_exact(key) : find_lower_bound(key);
        ans.found = (hit >= 0);
        ans.index = (hit >= 0) ? hit[stbs_pkg::ADDR_W-1:0] : '0;
        pending_answers = {pending_answers, ans};
    endfunction

    function void check_answer(logic found, logic [stbs_pkg::ADDR_W-1:0] index);
        t_answer want;
        if (pending_answers.size() == 0) begin
            $error("unexpected result word: found %0d, result_index %0d", found, index);
            fail_count++;
            return;
        end
        want = pending_answers.pop_front();
        if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            fail_count++;
        end
        if (index !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, index);
            fail_count++;
        end
    endfunction
endclass

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 90;
    localparam int SWAP_WORDS   = 30;
    localparam int FREE_WORDS   = 60;
    localparam int KEY_MIN      = 32'sh8000_0000;
    localparam int KEY_MAX      = 32'sh7fff_ffff;

    localparam logic [stbs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [stbs_pkg::ENTRY_COUNT_W-1:0] i_cfg_wdata;

    int unsigned send_idle_pct = 22;
    int unsigned recv_idle_pct = 58;
    int          sent_words    = 0;
    int          stall_cycles  = 0;

    table_search_tracker tracker = new();

    stbs_in_if  item_if();
    stbs_out_if result_if();

    sorted_table_binary_search_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready) begin
            tracker.check_answer(result_if.found, result_if.result_index);
        end
    end

    // Ends the run when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_if.valid && item_if.ready) ||
            (result_if.valid && result_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [stbs_pkg::MODE_W-1:0] mode, input int key,
                             input int addr);
        logic [stbs_pkg::ADDR_W-1:0] addr_bits;
        addr_bits = addr[stbs_pkg::ADDR_W-1:0];
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.mode          <= mode;
        item_if.key_value     <= key;
        item_if.entry_address <= addr_bits;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        tracker.note_word(mode, key, addr_bits);
        sent_words++;
        @(negedge i_clk);
    endtask

    // Holds the input off until every query has answered, then lets the
    // last load or search settle.
    task automatic drain();
        item_if.valid <= 1'b0;
        while (tracker.pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_entry_count(input int unsigned value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[stbs_pkg::ENTRY_COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_entry_count(value[stbs_pkg::ENTRY_COUNT_W-1:0]);
    endtask

    // Wide tables spread over the whole key range; dense ones repeat values.
    task automatic load_ascending(input int n, input bit wide);
        longint      level;
        int unsigned step_max;
        step_max = wide ? 32'hFFFF_FFFF / n : 3;
        level    = wide ? longint'(KEY_MIN) : longint'(int'($urandom()));
        for (int i = 0; i < n; i++) begin
            level += $urandom_range(0, step_max);
            if (level > KEY_MAX) level = KEY_MAX;
            send_word(stbs_pkg::MODE_LOAD, int'(level), i);
        end
    endtask

    task automatic send_query(input int n);
        int                          key;
        int                          pick;
        logic [stbs_pkg::MODE_W-1:0] mode;
        mode = $urandom_range(0, 1) ? stbs_pkg::MODE_EXACT : stbs_pkg::MODE_LOWER;
        pick = $urandom_range(0, 9);
        if (n == 0 || pick >= 8) begin
            key = $urandom();
        end else if (pick == 7) begin
            key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
        end else begin
            key = tracker.entry_vals[$urandom_range(0, n - 1)];
            if (pick == 5) key = key - 1;
            else if (pick == 6) key = key + 1;
        end
        send_word(mode, key, $urandom_range(0, TABLE_ENTRIES - 1));
    endtask

    task automatic random_phase();
        int unsigned count_value;
        int          n;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) count_value = 0;
        else if (pick < 70) count_value = $urandom_range(1, 16);
        else if (pick < 90) count_value = $urandom_range(17, 128);
        else if (pick < 97) count_value = $urandom_range(129, TABLE_ENTRIES - 1);
        else count_value = $urandom_range(TABLE_ENTRIES, 2047);
        write_entry_count(count_value);
        n = tracker.live_entries();
        // Large counts search whatever the table already holds.
        if (n > 0 && n <= 128) load_ascending(n, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(4, 12)) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_word(stbs_pkg::MODE_LOAD, $urandom(),
                          $urandom_range(0, TABLE_ENTRIES - 1));
            end else if (pick == 1) begin
                send_word(MODE_UNUSED, $urandom(), $urandom_range(0, TABLE_ENTRIES - 1));
            end else begin
                send_query(n);
            end
        end
    endtask

    initial begin
        int base_words;
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        item_if.valid         <= 1'b0;
        item_if.mode          <= stbs_pkg::MODE_LOAD;
        item_if.key_value     <= '0;
        item_if.entry_address <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table and the unused mode.
        send_word(stbs_pkg::MODE_EXACT, 0, 0);
        send_word(stbs_pkg::MODE_LOWER, KEY_MIN, 0);
        send_word(MODE_UNUSED, -1, TABLE_ENTRIES - 1);

        send_word(stbs_pkg::MODE_LOAD, KEY_MIN, 0);
        send_word(stbs_pkg::MODE_LOAD, -1, 1);
        send_word(stbs_pkg::MODE_LOAD, 0, 2);
        send_word(stbs_pkg::MODE_LOAD, 0, 3);
        send_word(stbs_pkg::MODE_LOAD, KEY_MAX, 4);
        send_word(stbs_pkg::MODE_LOAD, 5, TABLE_ENTRIES - 1);

        write_entry_count(5);
        send_word(stbs_pkg::MODE_EXACT, KEY_MIN, 0);
        send_word(stbs_pkg::MODE_EXACT, KEY_MAX, 0);
        send_word(stbs_pkg::MODE_EXACT, 0, 0);
        send_word(stbs_pkg::MODE_EXACT, 1, 0);
        send_word(stbs_pkg::MODE_LOWER, KEY_MIN, 0);
        send_word(stbs_pkg::MODE_LOWER, 1, 0);
        send_word(stbs_pkg::MODE_LOWER, -5, 0);
        send_word(MODE_UNUSED, 0, 0);

        // With the largest entry dropped, no entry is at least the key.
        write_entry_count(4);
        send_word(stbs_pkg::MODE_LOWER, KEY_MAX, 0);
        send_word(stbs_pkg::MODE_EXACT, KEY_MAX, 0);
        send_word(stbs_pkg::MODE_LOWER, 0, 0);

        write_entry_count(1);
        send_word(stbs_pkg::MODE_EXACT, KEY_MIN, 0);
        send_word(stbs_pkg::MODE_LOWER, -1, 0);

        // Full table, then a count above the depth.
        load_ascending(TABLE_ENTRIES, 1'b1);
        write_entry_count(TABLE_ENTRIES);
        repeat (20) send_query(TABLE_ENTRIES);
        write_entry_count(2047);
        repeat (10) send_query(tracker.live_entries());

        base_words = sent_words;
        while (sent_words - base_words < RANDOM_WORDS) begin
            if (sent_words - base_words >= FREE_WORDS) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent_words - base_words >= SWAP_WORDS) begin
                send_idle_pct = 58;
                recv_idle_pct = 22;
            end
            random_phase();
        end

        drain();
        if (tracker.fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
